// ----- rtl/qks_pkg.sv -----
// Shared types and codes for the quickselect order-statistic block.
// No dependencies.
`default_nettype none
package qks_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int PTR_W           = 12;   // signed pointer: -1 .. 1024

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;   // unused, ignored

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic        [1:0]  cmd;
        logic        [9:0]  element_index;
        logic signed [31:0] element_value;
        logic        [9:0]  range_start;
        logic        [10:0] range_end;
        logic        [9:0]  rank;
    } t_cmd_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               status;
    } t_result_word;

endpackage
`default_nettype wire

// ----- rtl/qks_mem.sv -----
// Element store: one write port, two registered read ports.
// Depends on nothing.
`default_nettype none
module qks_mem #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire        [AW-1:0]     i_waddr,
    input  wire signed [31:0]       i_wdata,
    input  wire        [AW-1:0]     i_raddr_a,
    input  wire        [AW-1:0]     i_raddr_b,
    output logic signed [31:0]      o_rdata_a,
    output logic signed [31:0]      o_rdata_b
);

    logic signed [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

// ----- rtl/quickselect_kth_smallest.sv -----
// Quickselect order-statistic store: top level with command sequencer.
// Depends on qks_pkg and qks_mem.
//
// A write word gives no result; a write with a bad index is dropped. A read
// word's result is strobed in the cycle in which busy falls. A select word
// reorders [range_start, range_end) in place and returns the value that lands
// at index rank, the (rank - range_start)-th smallest counting from zero. Each
// quickselect pass fetches the pivot and swaps it to the top of the range, runs
// partition steps (an exchanged pair takes a second write) and places the pivot
// after the final pointer check; the store has a single write port, so each
// swap is done as two writes. Bad read indexes, ranges or ranks return status 1
// with value 0 at once and leave the store alone. Results are one-cycle
// strobes on o_result_valid; the receiver cannot stall them, so it must take
// every word as it comes. Entries must be written before being read.
`default_nettype none
module quickselect_kth_smallest #(
    parameter int STORE_DEPTH = qks_pkg::STORE_DEPTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  qks_pkg::t_cmd_word     i_cmd,
    output logic                   o_busy,
    output logic                   o_result_valid,
    output qks_pkg::t_result_word  o_result
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = qks_pkg::PTR_W;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_RD_OUT = 12'b0000_0000_0010,
        S_PV_RD  = 12'b0000_0000_0100,
        S_PV_CMP = 12'b0000_0000_1000,
        S_PV_W2  = 12'b0000_0001_0000,
        S_PT_RD  = 12'b0000_0010_0000,
        S_PT_CMP = 12'b0000_0100_0000,
        S_PT_W2  = 12'b0000_1000_0000,
        S_FN_CMP = 12'b0001_0000_0000,
        S_FN_W2  = 12'b0010_0000_0000,
        S_K_RD   = 12'b0100_0000_0000,
        S_K_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [PW-1:0] r_lo, n_lo, r_hi, n_hi, r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [31:0]   r_pivot, n_pivot, r_tmp, n_tmp;
    logic                 r_valid, n_valid;
    qks_pkg::t_result_word r_res, n_res;

    // memory port controls
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr_a, mem_raddr_b;
    logic signed [31:0]   mem_wdata, rd_a, rd_b;

    logic                 accept, idx_ok, sel_bad, right_small, left_big;
    logic signed [PW-1:0] mid, ext_start, ext_end, ext_rank, nar_lo, nar_hi;

    function automatic logic [AW-1:0] f_addr(input logic signed [PW-1:0] p);
        return AW'(unsigned'(p));
    endfunction

    qks_mem #(.DEPTH(STORE_DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign accept    = i_start && (r_state == S_IDLE);
    assign ext_start = PW'(i_cmd.range_start);
    assign ext_end   = PW'(i_cmd.range_end);
    assign ext_rank  = PW'(i_cmd.rank);
    assign idx_ok    = 32'(i_cmd.element_index) < STORE_DEPTH;
    assign sel_bad   = (ext_start >= ext_end) || (32'(i_cmd.range_end) > STORE_DEPTH)
                    || (ext_rank < ext_start) || (ext_rank >= ext_end);
    // middle of the live range; hi - lo is positive here
    assign mid         = r_lo + ((r_hi - r_lo) >>> 1);
    assign right_small = rd_b < r_pivot;
    assign left_big    = r_pivot < rd_a;
    // narrowing to the side that holds the rank
    assign nar_lo      = (r_k > r_i) ? r_i + PW'(1) : r_lo;
    assign nar_hi      = (r_k > r_i) ? r_hi : r_i - PW'(1);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_pivot     = r_pivot;
        n_tmp       = r_tmp;
        n_valid     = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = AW'(i_cmd.element_index);
        mem_wdata   = i_cmd.element_value;
        mem_raddr_a = AW'(i_cmd.element_index);
        mem_raddr_b = f_addr(r_hi);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.cmd)
                        qks_pkg::CMD_WRITE: begin
                            mem_we = idx_ok;
                        end
                        qks_pkg::CMD_READ: begin
                            if (idx_ok) begin
                                n_state = S_RD_OUT;
                            end else begin
                                n_valid = 1'b1;
                                n_res   = '{result_value: '0, status: qks_pkg::ST_ERR};
                            end
                        end
                        qks_pkg::CMD_SELECT: begin
                            if (sel_bad) begin
                                n_valid = 1'b1;
                                n_res   = '{result_value: '0, status: qks_pkg::ST_ERR};
                            end else begin
                                n_lo    = ext_start;
                                n_hi    = ext_end - PW'(1);
                                n_k     = ext_rank;
                                n_state = (ext_start < ext_end - PW'(1)) ? S_PV_RD : S_K_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_OUT: begin
                n_valid = 1'b1;
                n_res   = '{result_value: rd_a, status: qks_pkg::ST_OK};
                n_state = S_IDLE;
            end
            S_PV_RD: begin
                mem_raddr_a = f_addr(mid);
                mem_raddr_b = f_addr(r_hi);
                n_state     = S_PV_CMP;
            end
            S_PV_CMP: begin
                // pivot to the top of the range
                n_pivot   = rd_a;
                mem_we    = 1'b1;
                mem_waddr = f_addr(mid);
                mem_wdata = rd_b;
                n_state   = S_PV_W2;
            end
            S_PV_W2: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_hi);
                mem_wdata = r_pivot;
                n_i       = r_lo;
                n_j       = r_hi - PW'(1);
                n_state   = S_PT_RD;
            end
            S_PT_RD: begin
                mem_raddr_a = f_addr(r_i);
                mem_raddr_b = f_addr(r_j);
                n_state     = (r_j >= r_i) ? S_PT_CMP : S_FN_CMP;
            end
            S_PT_CMP: begin
                n_state = S_PT_RD;
                if (right_small && left_big) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(r_i);
                    mem_wdata = rd_b;
                    n_tmp     = rd_a;
                    n_state   = S_PT_W2;
                end else if (right_small) begin
                    n_i = r_i + PW'(1);
                end else if (left_big) begin
                    n_j = r_j - PW'(1);
                end else begin
                    n_i = r_i + PW'(1);
                    n_j = r_j - PW'(1);
                end
            end
            S_PT_W2: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_j);
                mem_wdata = r_tmp;
                n_i       = r_i + PW'(1);
                n_j       = r_j - PW'(1);
                n_state   = S_PT_RD;
            end
            S_FN_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_hi);
                mem_wdata = rd_a;
                n_state   = S_FN_W2;
            end
            S_FN_W2: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_i);
                mem_wdata = r_pivot;
                if (r_i == r_k) begin
                    n_valid = 1'b1;
                    n_res   = '{result_value: r_pivot, status: qks_pkg::ST_OK};
                    n_state = S_IDLE;
                end else begin
                    n_lo    = nar_lo;
                    n_hi    = nar_hi;
                    n_state = (nar_lo < nar_hi) ? S_PV_RD : S_K_RD;
                end
            end
            S_K_RD: begin
                mem_raddr_a = f_addr(r_k);
                n_state     = S_K_OUT;
            end
            S_K_OUT: begin
                n_valid = 1'b1;
                n_res   = '{result_value: rd_a, status: qks_pkg::ST_OK};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_pivot <= n_pivot;
        r_tmp   <= n_tmp;
        r_res   <= n_res;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_res;

`ifndef NO_ASSERTIONS
    // an error word always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == qks_pkg::ST_ERR |-> o_result.result_value == 0)
        else $error("error word with non-zero value");

    // a result only follows an accepted word or sequencer work
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(o_busy) || $past(i_start))
        else $error("result without cause");

    // partition pointers never leave the live range
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PT_CMP |-> r_i >= r_lo && r_j <= r_hi - 1)
        else $error("partition pointer outside range");
`endif

endmodule
`default_nettype wire

// ----- sim/quickselect_kth_smallest_test.sv -----
// Self-checking bench for quickselect_kth_smallest: writes, reads and selects
// checked against an in-bench order-statistic store. Depends on qks_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module quickselect_kth_smallest_test;

    localparam int DEPTH = 1024;
    localparam int N_ITEMS = 1300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    qks_pkg::t_cmd_word     i_cmd = '0;
    logic                   o_busy;
    logic                   o_result_valid;
    qks_pkg::t_result_word  o_result;

    quickselect_kth_smallest DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_result_valid(o_result_valid), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // --- stimulus bookkeeping ---
    qks_pkg::t_cmd_word     pending_words[$];
    qks_pkg::t_result_word  expected_results[$];
    bit            gen_written[DEPTH];   // generator's view of which entries hold data
    int            words_accepted = 0;
    int            mismatches = 0;
    bit            gen_done = 1'b0;
    bit            word_taken = 1'b0;

    // --- predictor state: the element store as the block should hold it ---
    logic signed [31:0] shadow_store[DEPTH];

    task automatic swap_shadow(input int p, input int q);
        logic signed [31:0] t;
        t = shadow_store[p];
        shadow_store[p] = shadow_store[q];
        shadow_store[q] = t;
    endtask

    // middle pivot, two-pointer partition, narrow to the side holding the rank
    task automatic quickselect_shadow(input int lo_in, input int hi_in, input int k);
        int lo, hi, mid, i, j;
        logic signed [31:0] pivot;
        bit right_small, left_big;
        lo = lo_in;
        hi = hi_in;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            swap_shadow(mid, hi);
            pivot = shadow_store[hi];
            i = lo;
            j = hi - 1;
            while (j >= i) begin
                right_small = shadow_store[j] < pivot;
                left_big    = pivot < shadow_store[i];
                if (right_small && left_big) begin
                    swap_shadow(i, j);
                    i++;
                    j--;
                end else if (right_small) begin
                    i++;
                end else if (left_big) begin
                    j--;
                end else begin
                    i++;
                    j--;
                end
            end
            swap_shadow(i, hi);
            if (i == k) return;
            if (k > i) lo = i + 1;
            else hi = i - 1;
        end
    endtask

    // apply one accepted word to the shadow store; queue its result if any
    task automatic predict_word(input qks_pkg::t_cmd_word w);
        qks_pkg::t_result_word r;
        int s, e, k;
        s = w.range_start;
        e = w.range_end;
        k = w.rank;
        case (w.cmd)
            qks_pkg::CMD_WRITE: shadow_store[w.element_index] = w.element_value;
            qks_pkg::CMD_READ: begin
                r.result_value = shadow_store[w.element_index];
                r.status = qks_pkg::ST_OK;
                expected_results.push_back(r);
            end
            qks_pkg::CMD_SELECT: begin
                if (s >= e || e > DEPTH || k < s || k >= e) begin
                    r.result_value = '0;
                    r.status = qks_pkg::ST_ERR;
                end else begin
                    quickselect_shadow(s, e - 1, k);
                    r.result_value = shadow_store[k];
                    r.status = qks_pkg::ST_OK;
                end
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // --- generator helpers ---
    function automatic qks_pkg::t_cmd_word noise_word();
        qks_pkg::t_cmd_word w;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        w = noise[$bits(qks_pkg::t_cmd_word)-1:0];
        return w;
    endfunction

    task automatic push_write(input int idx, input logic signed [31:0] v);
        qks_pkg::t_cmd_word w;
        w = noise_word();
        w.cmd = qks_pkg::CMD_WRITE;
        w.element_index = 10'(idx);
        w.element_value = v;
        gen_written[idx] = 1'b1;
        pending_words.push_back(w);
    endtask

    task automatic push_read(input int idx);
        qks_pkg::t_cmd_word w;
        w = noise_word();
        w.cmd = qks_pkg::CMD_READ;
        w.element_index = 10'(idx);
        pending_words.push_back(w);
    endtask

    task automatic push_select(input int s, input int e, input int k);
        qks_pkg::t_cmd_word w;
        w = noise_word();
        w.cmd = qks_pkg::CMD_SELECT;
        w.range_start = 10'(s);
        w.range_end = 11'(e);
        w.rank = 10'(k);
        pending_words.push_back(w);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000 + $urandom_range(0, 3);
            1: return 32'sh7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 7) - 4;   // small, many duplicates
            default: return $urandom;
        endcase
    endfunction

    // fill any holes in the range and rewrite some entries at random, then select inside it
    task automatic select_sequence(input int s, input int e);
        for (int x = s; x < e; x++)
            if (!gen_written[x] || $urandom_range(0, 3) == 0) push_write(x, random_value());
        push_select(s, e, $urandom_range(s, e - 1));
    endtask

    initial begin
        int s, len, idx;
        qks_pkg::t_cmd_word w;
        // directed: value extremes, duplicates, top index
        push_write(0, 32'sh8000_0000);
        push_write(1, 32'sh7fff_ffff);
        push_write(2, 32'sh0);
        push_write(3, -32'sd1);
        push_write(4, 32'sh7fff_ffff);
        push_write(5, 32'sd1);
        push_write(6, 32'sh8000_0000);
        push_write(7, 32'sd1);
        push_write(DEPTH - 1, -32'sd5);
        push_read(0);
        push_read(DEPTH - 1);
        push_select(0, 8, 0);
        push_select(0, 8, 7);
        push_select(0, 8, 3);
        push_select(DEPTH - 1, DEPTH, DEPTH - 1);   // one-element range at the top
        push_select(2, 3, 2);
        // bad selects: empty range, reversed range, end past the store, rank below, rank at end
        push_select(5, 5, 5);
        push_select(6, 2, 3);
        push_select(1000, 2047, 1000);
        push_select(4, 8, 3);
        push_select(0, 8, 8);
        // unused command
        w = noise_word();
        w.cmd = qks_pkg::CMD_SPARE;
        pending_words.push_back(w);
        push_read(4);
        // random: mostly well-formed select sequences with random content
        while (pending_words.size() < N_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64)
                                                       : $urandom_range(1, 16);
                    s = $urandom_range(0, DEPTH - len);
                    select_sequence(s, s + len);
                end
                8, 9, 10: begin
                    idx = $urandom_range(0, DEPTH - 1);
                    if (gen_written[idx]) push_read(idx);
                    else push_write(idx, random_value());
                end
                11, 12: push_write($urandom_range(0, DEPTH - 1), random_value());
                13, 14: begin
                    w = noise_word();
                    w.cmd = qks_pkg::CMD_SELECT;
                    // only bad ranges or ranks here, so nothing unwritten is touched
                    if (!(w.range_start >= w.range_end || w.range_end > DEPTH ||
                          w.rank < w.range_start || w.rank >= w.range_end))
                        w.rank = w.range_start - 10'd1;
                    if (w.range_start == 0 && w.rank == 10'h3ff) w.range_end = '0;
                    pending_words.push_back(w);
                end
                15: begin
                    w = noise_word();
                    w.cmd = qks_pkg::CMD_SPARE;
                    pending_words.push_back(w);
                end
                default: begin
                    s = $urandom_range(0, DEPTH - 8);
                    select_sequence(s, s + $urandom_range(1, 8));
                end
            endcase
        end
        // one select ending at the top of the store
        select_sequence(DEPTH - 40, DEPTH);
        gen_done = 1'b1;
    end

    // --- reset: released at a falling edge ---
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // --- driver: presents words at the falling edge ---
    int idle_pct;
    always @(negedge i_clk) begin
        idle_pct = (words_accepted < N_ITEMS / 3) ? 38 :
                   (words_accepted < 2 * N_ITEMS / 3) ? 73 : 0;
        if (i_rst_n && gen_done && (!i_start || word_taken)) begin
            word_taken = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_cmd   <= pending_words[0];
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // --- monitor and acceptance: sampled at the rising edge ---
    always @(posedge i_clk) begin
        if (o_result_valid) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value %0d status %0d",
                             o_result.result_value, o_result.status);
            end else begin
                if (o_result.result_value !== expected_results[0].result_value ||
                    o_result.status !== expected_results[0].status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d, got %0d/%0d",
                                 expected_results[0].result_value,
                                 expected_results[0].status,
                                 o_result.result_value, o_result.status);
                end
                void'(expected_results.pop_front());
            end
        end
        if (i_rst_n && i_start && !o_busy) begin
            predict_word(pending_words.pop_front());
            words_accepted++;
            word_taken = 1'b1;
        end
    end

    // --- end of run ---
    initial begin
        wait (gen_done);
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        wait (expected_results.size() == 0 && !o_busy);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0 && !o_busy)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
